// ----- hdl/vision_position_frame_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// Vision position frame encoder assertion macros
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VISION_POSITION_FRAME_ENCODER_ASSERT_SVH
`define VISION_POSITION_FRAME_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define VPFE_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vpfe assertion failed");
`define VPFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vpfe assertion failed");
`else
`define VPFE_ASSERT_IMPLY(label, ante, cons)
`define VPFE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/vpfe_pkg.sv -----
// ----------------------------------------------------------------------------
// Vision position frame encoder package
// Frame layout constants, register indexes, mode codes and the CRC step.
// ----------------------------------------------------------------------------
package vpfe_pkg;

   localparam logic [1:0] REG_SYSTEM_IDENT    = 2'd0;
   localparam logic [1:0] REG_COMPONENT_IDENT = 2'd1;
   localparam logic [1:0] REG_MAX_AGE         = 2'd2;

   localparam logic [2:0] MODE_TRACKING  = 3'd0;
   localparam logic [2:0] MODE_RECOVERED = 3'd1;
   localparam logic [2:0] MODE_LOST      = 3'd2;
   localparam logic [2:0] MODE_SEARCH    = 3'd3;

   localparam logic [7:0] STX_V2        = 8'hfd;
   localparam logic [7:0] MSG_ID        = 8'd102;
   localparam logic [7:0] CRC_TAIL_BYTE = 8'd158;
   localparam logic [15:0] CRC_INIT     = 16'hffff;
   localparam logic [7:0] HDR_LEN       = 8'd10;
   localparam logic [7:0] PAYLOAD_FULL  = 8'd117;
   localparam logic [7:0] PAYLOAD_TRIM  = 8'd36;

   localparam logic [7:0] AT_LEN        = 8'd1;
   localparam logic [7:0] AT_SEQ        = 8'd4;
   localparam logic [7:0] AT_SYS        = 8'd5;
   localparam logic [7:0] AT_COMP       = 8'd6;
   localparam logic [7:0] AT_MSG        = 8'd7;
   localparam logic [7:0] AT_STAMP      = 8'd10;
   localparam logic [7:0] AT_NORTH      = 8'd18;
   localparam logic [7:0] AT_EAST       = 8'd22;
   localparam logic [7:0] AT_YAW        = 8'd38;
   localparam logic [7:0] AT_COV_HI     = 8'd44;
   localparam logic [7:0] AT_COV_TOP    = 8'd45;
   localparam logic [7:0] AT_RCOUNT     = 8'd126;
   localparam logic [7:0] COV_HI_BYTE   = 8'hc0;
   localparam logic [7:0] COV_TOP_BYTE  = 8'h7f;

   localparam logic [2:0] CHECK_LAST    = 3'd7;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] data);
      logic [7:0] t;
      t = data ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

   function automatic logic is_finite32(input logic [31:0] bits);
      return bits[30:23] != 8'hff;
   endfunction

endpackage

// ----- hdl/vision_position_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// Vision position frame encoder
// Flow: an accepted request runs the freshness checks in ST_CHECK; ST_DECIDE
// then either sends the frame from ST_SEND or emits a rejection from ST_REJECT.
// The byte sequencer feeds the CRC one byte per cycle, stalling only when a
// finished word waits for a full output; a new request is taken in ST_IDLE only.
// Reset is synchronous and active high; it restores the ids, max age and state.
// ----------------------------------------------------------------------------
`include "vision_position_frame_encoder_assert.svh"

module vision_position_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_pose_valid,
   input  logic [2:0]  req_loc_mode,
   input  logic        req_search_flag,
   input  logic [63:0] req_stamp_us,
   input  logic [63:0] req_now_us,
   input  logic        req_link_busy,
   input  logic [31:0] req_north_bits,
   input  logic [31:0] req_east_bits,
   input  logic [31:0] req_yaw_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_frame_word,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last_word,
   output logic        rsp_frame_sent,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECIDE,
      ST_REJECT,
      ST_SEND
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  system_ident_ff, system_ident_in;
   logic [7:0]  component_ident_ff, component_ident_in;
   logic [31:0] max_age_ff, max_age_in;
   logic [7:0]  frame_sequence_ff, frame_sequence_in;
   logic [7:0]  reset_count_ff, reset_count_in;
   logic        reset_armed_ff, reset_armed_in;
   logic        sent_before_ff, sent_before_in;
   logic [63:0] last_stamp_ff, last_stamp_in;
   logic [15:0] crc_work_ff, crc_work_in;
   logic [7:0]  byte_idx_ff, byte_idx_in;
   logic [1:0]  lane_ff, lane_in;
   logic [31:0] word_acc_ff, word_acc_in;
   logic [2:0]  check_cnt_ff, check_cnt_in;
   logic        ok_ff, ok_in;
   logic        nonzero_ff, nonzero_in;
   logic        borrow_now_ff, borrow_now_in;
   logic        borrow_age_ff, borrow_age_in;
   logic        borrow_last_ff, borrow_last_in;
   logic [63:0] stamp_ff, stamp_in;
   logic [63:0] now_ff, now_in;
   logic [31:0] north_ff, north_in;
   logic [31:0] east_ff, east_in;
   logic [31:0] yaw_ff, yaw_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_count_ff, rsp_count_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_sent_ff, rsp_sent_in;

   logic        out_free;
   logic [8:0]  diff_now;
   logic [8:0]  diff_age;
   logic [8:0]  diff_last;
   logic [7:0]  age_byte;
   logic        pass;
   logic        long_frame;
   logic [7:0]  frame_len;
   logic [7:0]  last_idx;
   logic [7:0]  offset;
   logic [7:0]  cur_byte;
   logic [15:0] crc_final;
   logic        completing;
   logic        advance;
   logic [31:0] word_next;

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_word = rsp_word_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_last_word  = rsp_last_ff;
   assign rsp_frame_sent = rsp_sent_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign age_byte   = check_cnt_ff[2] ? 8'h00 : max_age_ff[{check_cnt_ff[1:0], 3'b000} +: 8];
   assign diff_now   = {1'b0, now_ff[7:0]} - {1'b0, stamp_ff[7:0]} - {8'h00, borrow_now_ff};
   assign diff_age   = {1'b0, age_byte} - {1'b0, diff_now[7:0]} - {8'h00, borrow_age_ff};
   assign diff_last  = {1'b0, last_stamp_ff[7:0]} - {1'b0, stamp_ff[7:0]}
                       - {8'h00, borrow_last_ff};
   assign pass       = ok_ff && nonzero_ff && !borrow_now_ff && !borrow_age_ff && borrow_last_ff;
   assign long_frame = reset_count_ff != 8'h00;
   assign frame_len  = vpfe_pkg::HDR_LEN
                       + (long_frame ? vpfe_pkg::PAYLOAD_FULL : vpfe_pkg::PAYLOAD_TRIM);
   assign last_idx   = frame_len + 8'd1;
   assign crc_final  = vpfe_pkg::crc_add(crc_work_ff, vpfe_pkg::CRC_TAIL_BYTE);
   assign completing = lane_ff == 2'd3 || byte_idx_ff == last_idx;
   assign advance    = state_ff == ST_SEND && (!completing || out_free);
   assign word_next  = word_acc_ff | ({24'h000000, cur_byte} << {lane_ff, 3'b000});

   // Byte generator for the frame position held in the byte index.
   always_comb begin
      offset   = 8'h00;
      cur_byte = 8'h00;
      if (byte_idx_ff == frame_len) begin
         cur_byte = crc_final[7:0];
      end else if (byte_idx_ff == last_idx) begin
         cur_byte = crc_final[15:8];
      end else begin
         unique case (byte_idx_ff) inside
            8'd0:      cur_byte = vpfe_pkg::STX_V2;
            vpfe_pkg::AT_LEN: begin
               cur_byte = frame_len - vpfe_pkg::HDR_LEN;
            end
            vpfe_pkg::AT_SEQ:  cur_byte = frame_sequence_ff;
            vpfe_pkg::AT_SYS:  cur_byte = system_ident_ff;
            vpfe_pkg::AT_COMP: cur_byte = component_ident_ff;
            vpfe_pkg::AT_MSG:  cur_byte = vpfe_pkg::MSG_ID;
            [8'd10:8'd17]: begin
               offset   = byte_idx_ff - vpfe_pkg::AT_STAMP;
               cur_byte = stamp_ff[{offset[2:0], 3'b000} +: 8];
            end
            [8'd18:8'd21]: begin
               offset   = byte_idx_ff - vpfe_pkg::AT_NORTH;
               cur_byte = north_ff[{offset[1:0], 3'b000} +: 8];
            end
            [8'd22:8'd25]: begin
               offset   = byte_idx_ff - vpfe_pkg::AT_EAST;
               cur_byte = east_ff[{offset[1:0], 3'b000} +: 8];
            end
            [8'd38:8'd41]: begin
               offset   = byte_idx_ff - vpfe_pkg::AT_YAW;
               cur_byte = yaw_ff[{offset[1:0], 3'b000} +: 8];
            end
            vpfe_pkg::AT_COV_HI:  cur_byte = vpfe_pkg::COV_HI_BYTE;
            vpfe_pkg::AT_COV_TOP: cur_byte = vpfe_pkg::COV_TOP_BYTE;
            vpfe_pkg::AT_RCOUNT:  cur_byte = reset_count_ff;
            default:              cur_byte = 8'h00;
         endcase
      end
   end

   always_comb begin
      state_in           = state_ff;
      system_ident_in    = system_ident_ff;
      component_ident_in = component_ident_ff;
      max_age_in         = max_age_ff;
      frame_sequence_in  = frame_sequence_ff;
      reset_count_in     = reset_count_ff;
      reset_armed_in     = reset_armed_ff;
      sent_before_in     = sent_before_ff;
      last_stamp_in      = last_stamp_ff;
      crc_work_in        = crc_work_ff;
      byte_idx_in        = byte_idx_ff;
      lane_in            = lane_ff;
      word_acc_in        = word_acc_ff;
      check_cnt_in       = check_cnt_ff;
      ok_in              = ok_ff;
      nonzero_in         = nonzero_ff;
      borrow_now_in      = borrow_now_ff;
      borrow_age_in      = borrow_age_ff;
      borrow_last_in     = borrow_last_ff;
      stamp_in           = stamp_ff;
      now_in             = now_ff;
      north_in           = north_ff;
      east_in            = east_ff;
      yaw_in             = yaw_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_word_in        = rsp_word_ff;
      rsp_count_in       = rsp_count_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_sent_in        = rsp_sent_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (csr_index)
            vpfe_pkg::REG_SYSTEM_IDENT:    system_ident_in    = csr_wdata[7:0];
            vpfe_pkg::REG_COMPONENT_IDENT: component_ident_in = csr_wdata[7:0];
            vpfe_pkg::REG_MAX_AGE:         max_age_in         = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               stamp_in       = req_stamp_us;
               now_in         = req_now_us;
               north_in       = req_north_bits;
               east_in        = req_east_bits;
               yaw_in         = req_yaw_bits;
               reset_armed_in = reset_armed_ff || req_search_flag
                                || req_loc_mode == vpfe_pkg::MODE_RECOVERED
                                || req_loc_mode == vpfe_pkg::MODE_LOST
                                || req_loc_mode == vpfe_pkg::MODE_SEARCH;
               ok_in          = req_pose_valid && req_loc_mode == vpfe_pkg::MODE_TRACKING
                                && vpfe_pkg::is_finite32(req_north_bits)
                                && vpfe_pkg::is_finite32(req_east_bits)
                                && vpfe_pkg::is_finite32(req_yaw_bits)
                                && !req_link_busy;
               nonzero_in     = 1'b0;
               borrow_now_in  = 1'b0;
               borrow_age_in  = 1'b0;
               borrow_last_in = 1'b0;
               check_cnt_in   = 3'd0;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            nonzero_in     = nonzero_ff || stamp_ff[7:0] != 8'h00;
            borrow_now_in  = diff_now[8];
            borrow_age_in  = diff_age[8];
            borrow_last_in = diff_last[8];
            stamp_in       = {stamp_ff[7:0], stamp_ff[63:8]};
            last_stamp_in  = {last_stamp_ff[7:0], last_stamp_ff[63:8]};
            now_in         = {8'h00, now_ff[63:8]};
            check_cnt_in   = check_cnt_ff + 3'd1;
            if (check_cnt_ff == vpfe_pkg::CHECK_LAST) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (pass) begin
               if (reset_armed_ff) begin
                  if (sent_before_ff) begin
                     reset_count_in = reset_count_ff + 8'd1;
                  end
                  reset_armed_in = 1'b0;
               end
               sent_before_in = 1'b1;
               last_stamp_in  = stamp_ff;
               crc_work_in    = vpfe_pkg::CRC_INIT;
               byte_idx_in    = 8'd0;
               lane_in        = 2'd0;
               word_acc_in    = 32'h00000000;
               state_in       = ST_SEND;
            end else begin
               state_in = ST_REJECT;
            end
         end
         ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = 32'h00000000;
               rsp_count_in = 3'd0;
               rsp_last_in  = 1'b1;
               rsp_sent_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_SEND: begin
            if (advance) begin
               if (byte_idx_ff != 8'd0 && byte_idx_ff < frame_len) begin
                  crc_work_in = vpfe_pkg::crc_add(crc_work_ff, cur_byte);
               end
               if (completing) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = word_next;
                  rsp_count_in = {1'b0, lane_ff} + 3'd1;
                  rsp_last_in  = byte_idx_ff == last_idx;
                  rsp_sent_in  = 1'b1;
                  word_acc_in  = 32'h00000000;
                  lane_in      = 2'd0;
               end else begin
                  word_acc_in = word_next;
                  lane_in     = lane_ff + 2'd1;
               end
               if (byte_idx_ff == last_idx) begin
                  frame_sequence_in = frame_sequence_ff + 8'd1;
                  state_in          = ST_IDLE;
               end else begin
                  byte_idx_in = byte_idx_ff + 8'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      stamp_ff    <= stamp_in;
      now_ff      <= now_in;
      north_ff    <= north_in;
      east_ff     <= east_in;
      yaw_ff      <= yaw_in;
      word_acc_ff <= word_acc_in;
      crc_work_ff <= crc_work_in;
      rsp_word_ff <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff <= rsp_last_in;
      rsp_sent_ff <= rsp_sent_in;
      ok_ff       <= ok_in;
      nonzero_ff  <= nonzero_in;
      borrow_now_ff  <= borrow_now_in;
      borrow_age_ff  <= borrow_age_in;
      borrow_last_ff <= borrow_last_in;
      if (reset) begin
         state_ff           <= ST_IDLE;
         system_ident_ff    <= 8'd1;
         component_ident_ff <= 8'd1;
         max_age_ff         <= 32'd100000;
         frame_sequence_ff  <= 8'h00;
         reset_count_ff     <= 8'h00;
         reset_armed_ff     <= 1'b0;
         sent_before_ff     <= 1'b0;
         last_stamp_ff      <= 64'h0;
         byte_idx_ff        <= 8'h00;
         lane_ff            <= 2'd0;
         check_cnt_ff       <= 3'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         system_ident_ff    <= system_ident_in;
         component_ident_ff <= component_ident_in;
         max_age_ff         <= max_age_in;
         frame_sequence_ff  <= frame_sequence_in;
         reset_count_ff     <= reset_count_in;
         reset_armed_ff     <= reset_armed_in;
         sent_before_ff     <= sent_before_in;
         last_stamp_ff      <= last_stamp_in;
         byte_idx_ff        <= byte_idx_in;
         lane_ff            <= lane_in;
         check_cnt_ff       <= check_cnt_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   `VPFE_ASSERT_IMPLY(a_partial_word_in_frame, rsp_valid_ff && !rsp_last_ff, rsp_sent_ff && rsp_count_ff == 3'd4)
   `VPFE_ASSERT_IMPLY(a_reject_word_empty, rsp_valid_ff && !rsp_sent_ff, rsp_count_ff == 3'd0 && rsp_last_ff)
   `VPFE_ASSERT_IMPLY(a_byte_index_bound, state_ff == ST_SEND, byte_idx_ff <= last_idx)
   `VPFE_ASSERT_NEXT(a_sequence_steps, advance && byte_idx_ff == last_idx, frame_sequence_ff == $past(frame_sequence_ff) + 8'd1)

endmodule

// ----- tb/sv/vision_position_frame_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// Vision position frame encoder testbench
// Sends pose requests to the encoder and checks every emitted word against a
// local frame builder that tracks the sequence byte, the reset counter and the
// freshness rules. A directed table comes first, then four random phases with
// different sender ids and age limits, random stalls on both sides, and one
// long receiver hold-off that backs the encoder up into its request port.
// ----------------------------------------------------------------------------
module vision_position_frame_encoder_tb;

   localparam logic [1:0]  REG_SPARE          = 2'd3;
   localparam logic [2:0]  MODE_OTHER         = 3'd4;
   localparam logic [2:0]  MODE_HIGHEST       = 3'd7;
   localparam logic [15:0] X25_POLY_REFLECTED = 16'h8408;
   localparam logic [31:0] COVARIANCE_NAN     = 32'h7fc0_0000;
   localparam logic [63:0] ALL_ONES64         = 64'hffff_ffff_ffff_ffff;
   localparam int          AT_COVARIANCE      = 42;
   localparam int          FRAME_BYTES_MAX    = 129;
   localparam int          PHASE_ITEMS        = 40;
   localparam int          CHOKE_CYCLES       = 600;
   localparam int          SETTLE_CYCLES      = 32;

   typedef enum logic {VERDICT_MODEL, VERDICT_REFUSED} verdict_type;

   typedef struct packed {
      logic        pose_valid;
      logic [2:0]  loc_mode;
      logic        search_flag;
      logic [63:0] stamp_us;
      logic [63:0] now_us;
      logic        link_busy;
      logic [31:0] north_bits;
      logic [31:0] east_bits;
      logic [31:0] yaw_bits;
   } pose_type;

   typedef struct packed {
      verdict_type verdict;
      pose_type    pose;
   } row_type;

   typedef struct packed {
      logic [31:0] frame_word;
      logic [2:0]  byte_count;
      logic        last_word;
      logic        frame_sent;
   } word_type;

   localparam word_type REFUSAL = '{32'h0, 3'd0, 1'b1, 1'b0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_pose_valid = 1'b0;
   logic [2:0]  req_loc_mode = 3'd0;
   logic        req_search_flag = 1'b0;
   logic [63:0] req_stamp_us = 64'd0;
   logic [63:0] req_now_us = 64'd0;
   logic        req_link_busy = 1'b0;
   logic [31:0] req_north_bits = 32'd0;
   logic [31:0] req_east_bits = 32'd0;
   logic [31:0] req_yaw_bits = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_frame_word;
   logic [2:0]  rsp_byte_count;
   logic        rsp_last_word;
   logic        rsp_frame_sent;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_wdata = 32'd0;

   // Local copy of the encoder's settings and state.
   logic [7:0]  cfg_system = 8'd1;
   logic [7:0]  cfg_component = 8'd1;
   logic [31:0] cfg_max_age = 32'd100000;
   logic [7:0]  model_seq = 8'd0;
   logic [7:0]  bump_count = 8'd0;
   logic        bump_armed = 1'b0;
   logic        has_sent = 1'b0;
   logic [63:0] newest_stamp = 64'd0;

   word_type words_due[$];
   word_type want;
   logic  jitter_on = 1'b1;
   logic  choke_request = 1'b0;
   int    failures = 0;
   int    requests_sent = 0;
   int    frames_built = 0;
   int    refusals = 0;
   int    words_checked = 0;

   row_type pose_plan [22] = '{
      '{VERDICT_REFUSED, '{1'b0, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd100, 64'd100, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_MODEL,   '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd100, 64'd100, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_RECOVERED, 1'b0, 64'd200, 64'd200, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_MODEL,   '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd200, 64'd200, 1'b0,
                           32'hff7f_ffff, 32'h7f7f_ffff, 32'h8000_0000}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_LOST, 1'b0, 64'd250, 64'd250, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_SEARCH, 1'b0, 64'd260, 64'd260, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, MODE_OTHER, 1'b0, 64'd270, 64'd270, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, MODE_HIGHEST, 1'b1, 64'd280, 64'd280, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_MODEL,   '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b1, 64'd300, 64'd300, 1'b0,
                           32'h3f80_0000, 32'hbf80_0000, 32'h4049_0fdb}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd0, 64'd0, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd500, 64'd499, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd500, 64'd100501, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_MODEL,   '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd500, 64'd100500, 1'b0,
                           32'h007f_ffff, 32'h807f_ffff, 32'h7f00_0000}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd500, 64'd500, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd400, 64'd400, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd600, 64'd600, 1'b0,
                           32'h7f80_0000, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd600, 64'd600, 1'b0,
                           32'h0, 32'hffc0_0000, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd600, 64'd600, 1'b0,
                           32'h0, 32'h0, 32'hff80_0000}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd600, 64'd600, 1'b1,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd600, ALL_ONES64, 1'b0,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_REFUSED, '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, ALL_ONES64, ALL_ONES64, 1'b1,
                           32'h0, 32'h0, 32'h0}},
      '{VERDICT_MODEL,   '{1'b1, vpfe_pkg::MODE_TRACKING, 1'b0, 64'd700, 64'd700, 1'b0,
                           32'h0000_0001, 32'h8000_0001, 32'h7eff_ffff}}
   };

   vision_position_frame_encoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pose_valid  (req_pose_valid),
      .req_loc_mode    (req_loc_mode),
      .req_search_flag (req_search_flag),
      .req_stamp_us    (req_stamp_us),
      .req_now_us      (req_now_us),
      .req_link_busy   (req_link_busy),
      .req_north_bits  (req_north_bits),
      .req_east_bits   (req_east_bits),
      .req_yaw_bits    (req_yaw_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_word  (rsp_frame_word),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_word   (rsp_last_word),
      .rsp_frame_sent  (rsp_frame_sent),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] x25_fold(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = acc ^ {8'h00, data};
      repeat (8) r = r[0] ? ((r >> 1) ^ X25_POLY_REFLECTED) : (r >> 1);
      return r;
   endfunction

   function automatic logic pose_passes(input pose_type p);
      logic [63:0] age;
      age = p.now_us - p.stamp_us;
      return p.pose_valid && p.loc_mode == vpfe_pkg::MODE_TRACKING && p.stamp_us != 64'd0 &&
             p.stamp_us <= p.now_us && age <= {32'h0, cfg_max_age} &&
             p.stamp_us > newest_stamp && p.north_bits[30:23] != 8'hff &&
             p.east_bits[30:23] != 8'hff && p.yaw_bits[30:23] != 8'hff && !p.link_busy;
   endfunction

   function automatic void encode_pose(input pose_type p, ref word_type out[$]);
      logic [7:0]  octet [FRAME_BYTES_MAX];
      logic [15:0] crc;
      word_type    rec;
      int          i, k, len, total, words, cnt;
      if (p.search_flag || p.loc_mode == vpfe_pkg::MODE_RECOVERED ||
          p.loc_mode == vpfe_pkg::MODE_LOST || p.loc_mode == vpfe_pkg::MODE_SEARCH) begin
         bump_armed = 1'b1;
      end
      if (!pose_passes(p)) begin
         out.insert(out.size(), REFUSAL);
         return;
      end
      if (bump_armed) begin
         if (has_sent) begin
            bump_count = bump_count + 8'd1;
         end
         bump_armed = 1'b0;
      end
      for (i = 0; i < FRAME_BYTES_MAX; i++) octet[i] = 8'h00;
      octet[0] = vpfe_pkg::STX_V2;
      octet[vpfe_pkg::AT_SEQ] = model_seq;
      octet[vpfe_pkg::AT_SYS] = cfg_system;
      octet[vpfe_pkg::AT_COMP] = cfg_component;
      octet[vpfe_pkg::AT_MSG] = vpfe_pkg::MSG_ID;
      for (i = 0; i < 8; i++) begin
         octet[vpfe_pkg::AT_STAMP + i] = p.stamp_us[8 * i +: 8];
      end
      for (i = 0; i < 4; i++) begin
         octet[vpfe_pkg::AT_NORTH + i] = p.north_bits[8 * i +: 8];
         octet[vpfe_pkg::AT_EAST + i] = p.east_bits[8 * i +: 8];
         octet[vpfe_pkg::AT_YAW + i] = p.yaw_bits[8 * i +: 8];
         octet[AT_COVARIANCE + i] = COVARIANCE_NAN[8 * i +: 8];
      end
      octet[vpfe_pkg::AT_RCOUNT] = bump_count;
      len = vpfe_pkg::HDR_LEN + vpfe_pkg::PAYLOAD_FULL;
      while (len > vpfe_pkg::HDR_LEN + 1 && octet[len - 1] == 8'h00) len--;
      octet[vpfe_pkg::AT_LEN] = 8'(len - vpfe_pkg::HDR_LEN);
      crc = vpfe_pkg::CRC_INIT;
      for (i = 1; i < len; i++) begin
         crc = x25_fold(crc, octet[i]);
      end
      crc = x25_fold(crc, vpfe_pkg::CRC_TAIL_BYTE);
      octet[len] = crc[7:0];
      octet[len + 1] = crc[15:8];
      total = len + 2;
      model_seq = model_seq + 8'd1;
      newest_stamp = p.stamp_us;
      has_sent = 1'b1;
      words = (total + 3) / 4;
      for (k = 0; k < words; k++) begin
         cnt = total - 4 * k;
         if (cnt > 4) begin
            cnt = 4;
         end
         rec.frame_word = 32'h0;
         for (i = 0; i < cnt; i++) begin
            rec.frame_word[8 * i +: 8] = octet[4 * k + i];
         end
         rec.byte_count = 3'(cnt);
         rec.last_word = (k == words - 1);
         rec.frame_sent = 1'b1;
         out.insert(out.size(), rec);
      end
   endfunction

   function automatic logic [31:0] finite_bits();
      logic [31:0] v;
      v = $urandom;
      if (v[30:23] == 8'hff) begin
         v[23] = 1'b0;
      end
      return v;
   endfunction

   // Mostly well-formed poses that advance time, with arming states, single
   // broken conditions and fully random noise mixed in.
   function automatic pose_type make_pose();
      pose_type    p;
      int          pick;
      logic [63:0] age;
      logic [23:0] leap;
      logic [31:0] age_cap;
      pick = $urandom_range(0, 99);
      age_cap = (cfg_max_age < 32'd5000) ? cfg_max_age : 32'd5000;
      p.pose_valid = 1'b1;
      p.loc_mode = vpfe_pkg::MODE_TRACKING;
      p.search_flag = 1'b0;
      p.link_busy = 1'b0;
      p.north_bits = finite_bits();
      p.east_bits = finite_bits();
      p.yaw_bits = finite_bits();
      p.stamp_us = newest_stamp + 64'd1 + {32'h0, 32'($urandom_range(0, 1 << 20))};
      if ($urandom_range(0, 19) == 0) begin
         leap = 24'($urandom);
         p.stamp_us = p.stamp_us + {8'h00, leap, 32'h0};
      end
      case ($urandom_range(0, 2))
         0: age = 64'd0;
         1: age = {32'h0, cfg_max_age};
         default: age = {32'h0, 32'($urandom_range(0, age_cap))};
      endcase
      p.now_us = p.stamp_us + age;
      if (pick < 15) begin
         if ($urandom_range(0, 1) == 0) begin
            p.search_flag = 1'b1;
         end else begin
            p.loc_mode = 3'($urandom_range(vpfe_pkg::MODE_RECOVERED, vpfe_pkg::MODE_SEARCH));
         end
      end else if (pick < 30) begin
         case ($urandom_range(0, 6))
            0: p.pose_valid = 1'b0;
            1: p.stamp_us = 64'd0;
            2: p.now_us = p.stamp_us - 64'd1;
            3: p.now_us = p.stamp_us + {32'h0, cfg_max_age} + 64'd1;
            4: begin
               p.stamp_us = newest_stamp;
               p.now_us = newest_stamp;
            end
            5: begin
               case ($urandom_range(0, 2))
                  0: p.north_bits[30:23] = 8'hff;
                  1: p.east_bits[30:23] = 8'hff;
                  default: p.yaw_bits[30:23] = 8'hff;
               endcase
            end
            default: p.link_busy = 1'b1;
         endcase
      end else if (pick < 42) begin
         p.pose_valid = 1'($urandom_range(0, 1));
         p.loc_mode = 3'($urandom_range(0, 7));
         p.search_flag = 1'($urandom_range(0, 1));
         p.stamp_us = {32'($urandom), 32'($urandom)};
         p.now_us = {32'($urandom), 32'($urandom)};
         p.link_busy = 1'($urandom_range(0, 1));
         p.north_bits = $urandom;
         p.east_bits = $urandom;
         p.yaw_bits = $urandom;
         // Noise must never move the stamp far ahead and lock out later frames.
         if (pose_passes(p)) begin
            p.link_busy = 1'b1;
         end
      end
      return p;
   endfunction

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      case (index)
         vpfe_pkg::REG_SYSTEM_IDENT: cfg_system = value[7:0];
         vpfe_pkg::REG_COMPONENT_IDENT: cfg_component = value[7:0];
         vpfe_pkg::REG_MAX_AGE: cfg_max_age = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic send_pose(input pose_type p, input verdict_type verdict);
      word_type due[$];
      @(negedge clock);
      req_pose_valid = p.pose_valid;
      req_loc_mode = p.loc_mode;
      req_search_flag = p.search_flag;
      req_stamp_us = p.stamp_us;
      req_now_us = p.now_us;
      req_link_busy = p.link_busy;
      req_north_bits = p.north_bits;
      req_east_bits = p.east_bits;
      req_yaw_bits = p.yaw_bits;
      req_valid = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      encode_pose(p, due);
      requests_sent++;
      if (due[0].frame_sent) begin
         frames_built++;
      end else begin
         refusals++;
      end
      if (verdict == VERDICT_REFUSED) begin
         words_due.insert(words_due.size(), REFUSAL);
      end else begin
         foreach (due[i]) words_due.insert(words_due.size(), due[i]);
      end
   endtask

   task automatic idle_sender();
      int gap;
      if (!jitter_on || $urandom_range(0, 2) != 0) begin
         return;
      end
      gap = $urandom_range(1, 4);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         send_pose(make_pose(), VERDICT_MODEL);
         idle_sender();
      end
      drain();
   endtask

   function automatic void match_field(input string name, input logic [31:0] expected,
                                       input logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s expected %0h actual %0h", name, expected, actual);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (words_due.size() == 0) begin
            $error("word %0h with byte count %0d arrived with no request pending",
                   rsp_frame_word, rsp_byte_count);
            failures++;
         end else begin
            want = words_due.pop_front();
            words_checked++;
            match_field("frame_word", want.frame_word, rsp_frame_word);
            match_field("byte_count", {29'h0, want.byte_count}, {29'h0, rsp_byte_count});
            match_field("last_word", {31'h0, want.last_word}, {31'h0, rsp_last_word});
            match_field("frame_sent", {31'h0, want.frame_sent}, {31'h0, rsp_frame_sent});
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (choke_request) begin
            rsp_ready = 1'b0;
            repeat (CHOKE_CYCLES) @(negedge clock);
            choke_request = 1'b0;
         end else if (jitter_on && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (pose_plan[k]) begin
         send_pose(pose_plan[k].pose, pose_plan[k].verdict);
         idle_sender();
      end
      drain();

      // A zero system id with junk in the upper data bits, a component id of 0xff, and an age limit of zero.
      write_reg(vpfe_pkg::REG_SYSTEM_IDENT, 32'h5a5a_5a00);
      write_reg(vpfe_pkg::REG_COMPONENT_IDENT, 32'h0000_00ff);
      write_reg(vpfe_pkg::REG_MAX_AGE, 32'h0);
      write_reg(REG_SPARE, 32'hffff_ffff);
      run_phase(PHASE_ITEMS);

      write_reg(vpfe_pkg::REG_SYSTEM_IDENT, 32'h0000_00ff);
      write_reg(vpfe_pkg::REG_COMPONENT_IDENT, 32'h0);
      write_reg(vpfe_pkg::REG_MAX_AGE, 32'hffff_ffff);
      choke_request = 1'b1;
      run_phase(PHASE_ITEMS);

      write_reg(vpfe_pkg::REG_SYSTEM_IDENT, 32'($urandom_range(1, 255)));
      write_reg(vpfe_pkg::REG_COMPONENT_IDENT, 32'($urandom_range(1, 255)));
      write_reg(vpfe_pkg::REG_MAX_AGE, 32'($urandom_range(1, 2_000_000)));
      run_phase(PHASE_ITEMS);

      jitter_on = 1'b0;
      write_reg(vpfe_pkg::REG_SYSTEM_IDENT, 32'd1);
      write_reg(vpfe_pkg::REG_COMPONENT_IDENT, 32'd1);
      write_reg(vpfe_pkg::REG_MAX_AGE, 32'd100000);
      run_phase(PHASE_ITEMS);

      $display("Sent %0d pose requests (%0d framed, %0d refused), checked %0d words.",
               requests_sent, frames_built, refusals, words_checked);
      $display("Ids and age limits went from zero to full scale; reset counter ended at %0d.",
               bump_count);
      if (failures == 0) begin
         $display("vision_position_frame_encoder test passed");
      end else begin
         $display("vision_position_frame_encoder test failed");
      end
      $finish;
   end

   initial begin
      #9_000_000;
      $display("vision_position_frame_encoder test failed");
      $finish;
   end

endmodule

// ----- vision_position_frame_encoder.f -----
+incdir+hdl
hdl/vpfe_pkg.sv
hdl/vision_position_frame_encoder.sv
tb/sv/vision_position_frame_encoder_tb.sv
